// File: src/bvs_pkg.sv
// Package for the bit vector store: field widths, mode codes, payload structs
// and the internal operation and state types. No dependencies.
package bvs_pkg;

  localparam int unsigned MODE_W     = 4;
  localparam int unsigned POS_W      = 9;
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned POP_W      = 9;
  localparam int unsigned SIZE_RESET = 256;

  localparam logic [MODE_W-1:0] MODE_QUERY    = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SET_BIT  = 4'd1;
  localparam logic [MODE_W-1:0] MODE_CLR_BIT  = 4'd2;
  localparam logic [MODE_W-1:0] MODE_FLIP_BIT = 4'd3;
  localparam logic [MODE_W-1:0] MODE_SET_ALL  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_CLR_ALL  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_FLIP_ALL = 4'd6;
  localparam logic [MODE_W-1:0] MODE_SHL      = 4'd7;
  localparam logic [MODE_W-1:0] MODE_SHR      = 4'd8;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
  } bvs_in_t;

  typedef struct packed {
    logic             bit_value;
    logic             all_set;
    logic             any_set;
    logic [POP_W-1:0] pop_count;
    logic             range_error;
  } bvs_out_t;

  // Operation applied to every block during a sweep.
  typedef enum logic [3:0] {
    OP_QUERY,
    OP_SET_BIT,
    OP_CLR_BIT,
    OP_FLIP_BIT,
    OP_SET_ALL,
    OP_CLR_ALL,
    OP_FLIP_ALL,
    OP_SHL,
    OP_SHR,
    OP_TRIM,
    OP_INIT
  } bvs_op_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SWEEP  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } bvs_state_e;

endpackage

// File: src/bit_vector_store.sv
// Bit vector store top level: block memory, sweep pipeline, shift amount
// split and result register. Depends on bvs_pkg.
//
// Keeps a vector of MAX_BITS bits as NUM_BLOCKS blocks of BLOCK_BITS bits in
// a one-write, two-read synchronous memory. Every item sweeps the whole
// memory, one block per cycle: read, modify, write back, and count. Shifts
// take the same sweep: the shift amount is split into a block offset and a
// bit offset by a reciprocal multiply as the item is taken. A new item is
// taken only after the sweep of the block memory ends. The result lands in
// an output register, so the next item is taken while a result still waits.
// After reset the block runs a clearing pass over the memory and holds off
// input transfers; configuration writes are taken during it. A write of
// active_size saturates at MAX_BITS; one taken while idle also starts a trim
// sweep that zeros bits at or above the new size.
module bit_vector_store #(
  parameter int unsigned MAX_BITS   = 256,
  parameter int unsigned BLOCK_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bvs_pkg::bvs_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bvs_pkg::bvs_out_t          out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bvs_pkg::SIZE_W-1:0] cfg_data_i
);
  import bvs_pkg::*;

  localparam int unsigned NUM_BLOCKS = (MAX_BITS + BLOCK_BITS - 1) / BLOCK_BITS;
  localparam int unsigned SPAN       = NUM_BLOCKS * BLOCK_BITS;
  localparam int unsigned IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned OFF_W      = $clog2(BLOCK_BITS);
  localparam int unsigned ABS_W      = (($clog2(SPAN) > POS_W) ? $clog2(SPAN) : POS_W) + 1;
  localparam int unsigned SRC_W      = ABS_W + 1;
  localparam int unsigned CNT_W      = $clog2(SPAN + 1);
  localparam int unsigned PC_W       = $clog2(BLOCK_BITS + 1);
  localparam int unsigned SIZE_INIT  = (SIZE_RESET < MAX_BITS) ? SIZE_RESET : MAX_BITS;
  localparam logic signed [SRC_W-1:0] NB_S = SRC_W'(NUM_BLOCKS);
  // Rounded-up reciprocal of BLOCK_BITS; exact for every POS_W-bit amount.
  localparam int unsigned RCP_SH     = POS_W + OFF_W;
  localparam int unsigned RCP        = ((1 << RCP_SH) + BLOCK_BITS - 1) / BLOCK_BITS;
  localparam int unsigned PROD_W     = RCP_SH + POS_W;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  bvs_state_e            state_q, state_d;
  bvs_op_e               op_q, op_d, dec_op;
  logic [IDX_W-1:0]      step_q, step_d;
  logic                  down_q;
  logic [SIZE_W-1:0]     size_q;

  // Item payload held for the sweep
  logic [POS_W-1:0]      pos_q;
  logic                  err_q;

  // Shift amount split
  logic [PROD_W-1:0]     div_prod;
  logic [POS_W-1:0]      div_quo, div_rem;
  logic [POS_W-1:0]      quo_q;
  logic [OFF_W-1:0]      rem_q;

  logic in_fire, cfg_fire, in_range, is_vec_mode, step_last, out_free;
  logic [SIZE_W-1:0] cfg_sat;

  assign cfg_ready_o = (state_q == ST_IDLE) || (op_q == OP_INIT);
  // Hold off items while busy, and while a size write is offered so the two
  // never start in the same cycle.
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  assign cfg_sat = (ABS_W'(cfg_data_i) > ABS_W'(MAX_BITS)) ? SIZE_W'(MAX_BITS) : cfg_data_i;

  assign in_range    = in_data_i.position < size_q;
  assign is_vec_mode = in_data_i.mode inside {[MODE_SET_ALL:MODE_SHR]};

  // Decode the mode; an oversized shift is a plain clear, unused modes query.
  always_comb begin
    case (in_data_i.mode)
      MODE_QUERY:    dec_op = OP_QUERY;
      MODE_SET_BIT:  dec_op = OP_SET_BIT;
      MODE_CLR_BIT:  dec_op = OP_CLR_BIT;
      MODE_FLIP_BIT: dec_op = OP_FLIP_BIT;
      MODE_SET_ALL:  dec_op = OP_SET_ALL;
      MODE_CLR_ALL:  dec_op = OP_CLR_ALL;
      MODE_FLIP_ALL: dec_op = OP_FLIP_ALL;
      MODE_SHL:      dec_op = in_range ? OP_SHL : OP_CLR_ALL;
      MODE_SHR:      dec_op = in_range ? OP_SHR : OP_CLR_ALL;
      default:       dec_op = OP_QUERY;
    endcase
  end

  assign step_last = step_q == IDX_W'(NUM_BLOCKS - 1);

  // Pipeline valids (declared here, driven below)
  logic s1_valid_q, s2_valid_q;
  logic out_valid_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (cfg_fire) begin
          state_d = ST_SWEEP;
          op_d    = OP_TRIM;
          step_d  = '0;
        end else if (in_fire) begin
          op_d    = dec_op;
          step_d  = '0;
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        step_d = step_q + 1'b1;
        if (step_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        // Leave once the last block has been written back; the counter
        // stage finishes on the same edge.
        if (!s1_valid_q) begin
          state_d = (op_q == OP_TRIM || op_q == OP_INIT) ? ST_IDLE : ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      op_q    <= OP_INIT;
      step_q  <= '0;
      down_q  <= 1'b0;
      size_q  <= SIZE_W'(SIZE_INIT);
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      step_q  <= step_d;
      if (cfg_fire) size_q <= cfg_sat;
      if (state_q == ST_IDLE) begin
        // Walk top-down for a left shift so sources are read before overwrite.
        down_q <= in_fire && !cfg_fire && (dec_op == OP_SHL);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Split the shift amount by BLOCK_BITS: quotient from the reciprocal
  // multiply, remainder by multiply back and subtract.
  // ---------------------------------------------------------------------------
  assign div_prod = PROD_W'(in_data_i.position) * PROD_W'(RCP);
  assign div_quo  = div_prod[RCP_SH +: POS_W];
  assign div_rem  = in_data_i.position - div_quo * POS_W'(BLOCK_BITS);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pos_q <= in_data_i.position;
      err_q <= !is_vec_mode && !in_range;
      quo_q <= div_quo;
      rem_q <= div_rem[OFF_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Read issue: block under work and its source blocks
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]        k_cur;
  logic signed [SRC_W-1:0] k_s, q_s, lo_idx, hi_idx;
  logic                    lo_ok, hi_ok;
  logic [IDX_W-1:0]        lo_addr, hi_addr;

  assign k_cur = down_q ? IDX_W'(NUM_BLOCKS - 1) - step_q : step_q;
  assign k_s   = SRC_W'(k_cur);
  assign q_s   = SRC_W'(quo_q);

  always_comb begin
    case (op_q)
      OP_SHL: begin
        hi_idx = k_s - q_s;
        lo_idx = k_s - q_s - SRC_W'(1);
      end
      OP_SHR: begin
        lo_idx = k_s + q_s;
        hi_idx = k_s + q_s + SRC_W'(1);
      end
      default: begin
        lo_idx = k_s;
        hi_idx = k_s;
      end
    endcase
  end

  assign lo_ok   = (lo_idx >= 0) && (lo_idx < NB_S);
  assign hi_ok   = (hi_idx >= 0) && (hi_idx < NB_S);
  assign lo_addr = lo_ok ? lo_idx[IDX_W-1:0] : '0;
  assign hi_addr = hi_ok ? hi_idx[IDX_W-1:0] : '0;

  // ---------------------------------------------------------------------------
  // Block memory: one write port, two registered read ports. The walk order
  // never reads the block written in the same cycle, so no forwarding.
  // ---------------------------------------------------------------------------
  logic [BLOCK_BITS-1:0] blocks_q [NUM_BLOCKS];
  logic [BLOCK_BITS-1:0] rd_lo_q, rd_hi_q;
  logic [BLOCK_BITS-1:0] blk_new;
  logic [IDX_W-1:0]      s1_k_q;
  logic                  lo_ok_q, hi_ok_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) blocks_q[s1_k_q] <= blk_new;
    rd_lo_q <= blocks_q[lo_addr];
    rd_hi_q <= blocks_q[hi_addr];
  end

  always_ff @(posedge clk_i) begin
    s1_k_q  <= k_cur;
    lo_ok_q <= lo_ok;
    hi_ok_q <= hi_ok;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: modify the block and write it back
  // ---------------------------------------------------------------------------
  logic [ABS_W-1:0]        base;
  logic [BLOCK_BITS-1:0]   in_use, sel, old_lo, old_hi, blk_raw;
  logic [2*BLOCK_BITS-1:0] win, shl_w, shr_w;
  logic                    bit_hit;

  assign base   = ABS_W'(s1_k_q) * ABS_W'(BLOCK_BITS);
  assign old_lo = lo_ok_q ? rd_lo_q : '0;
  assign old_hi = hi_ok_q ? rd_hi_q : '0;
  assign win    = {old_hi, old_lo};
  assign shl_w  = win << rem_q;
  assign shr_w  = win >> rem_q;

  always_comb begin
    for (int j = 0; j < BLOCK_BITS; j++) begin
      in_use[j] = (base + ABS_W'(j)) < ABS_W'(size_q);
      sel[j]    = (base + ABS_W'(j)) == ABS_W'(pos_q);
    end
  end

  always_comb begin
    case (op_q)
      OP_SET_BIT:  blk_raw = old_lo | sel;
      OP_CLR_BIT:  blk_raw = old_lo & ~sel;
      OP_FLIP_BIT: blk_raw = old_lo ^ sel;
      OP_SET_ALL:  blk_raw = '1;
      OP_CLR_ALL:  blk_raw = '0;
      OP_FLIP_ALL: blk_raw = ~old_lo;
      OP_SHL:      blk_raw = shl_w[2*BLOCK_BITS-1:BLOCK_BITS];
      OP_SHR:      blk_raw = shr_w[BLOCK_BITS-1:0];
      OP_INIT:     blk_raw = '0;
      default:     blk_raw = old_lo;
    endcase
  end

  // Bits at or above the size stay zero; this also drops an out-of-range
  // single-bit update and reads its bit as zero.
  assign blk_new = blk_raw & in_use;
  assign bit_hit = |(blk_new & sel);

  // ---------------------------------------------------------------------------
  // Stage 2: count and flag
  // ---------------------------------------------------------------------------
  logic [BLOCK_BITS-1:0] nb_q, use_q;
  logic [PC_W-1:0]       blk_pop;
  logic [CNT_W-1:0]      cnt_q;
  logic                  any_q, all_q, bitv_q;

  assign blk_pop = PC_W'($countones(nb_q));

  always_ff @(posedge clk_i) begin
    nb_q  <= blk_new;
    use_q <= in_use;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      cnt_q      <= '0;
      any_q      <= 1'b0;
      all_q      <= 1'b1;
      bitv_q     <= 1'b0;
    end else begin
      s1_valid_q <= state_q == ST_SWEEP;
      s2_valid_q <= s1_valid_q;
      if (state_q == ST_IDLE) begin
        cnt_q  <= '0;
        any_q  <= 1'b0;
        all_q  <= 1'b1;
        bitv_q <= 1'b0;
      end else begin
        if (s1_valid_q && bit_hit) bitv_q <= 1'b1;
        if (s2_valid_q) begin
          cnt_q <= cnt_q + CNT_W'(blk_pop);
          if (|nb_q) any_q <= 1'b1;
          if (nb_q != use_q) all_q <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  bvs_out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FINISH && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH && out_free) begin
      res_q.bit_value   <= bitv_q;
      res_q.all_set     <= all_q;
      res_q.any_set     <= any_q;
      res_q.pop_count   <= POP_W'(cnt_q);
      res_q.range_error <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

`ifndef SYNTHESIS
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.any_set |-> out_data_o.pop_count == '0)
    else $error("pop_count nonzero on an empty vector");

  a_err_bit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.range_error |-> !out_data_o.bit_value)
    else $error("bit_value set for an out-of-range position");

  a_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(state_q == ST_SWEEP))
    else $error("block write outside a sweep");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside the finish state");
`endif

endmodule
